/* hw/rtl/newton_fractal_pixel_iterator_unit_assert.svh */
// Assertion helpers shared by the iterator modules.
`ifndef NEWTON_FRACTAL_PIXEL_ITERATOR_UNIT_ASSERT_SVH
`define NEWTON_FRACTAL_PIXEL_ITERATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NFPI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NFPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/nfpi_pkg.sv */
package nfpi_pkg;

   localparam int DEGREE_DEFAULT = 3;
   localparam int COEF_SEL_W = 3;
   localparam int FRAC = 20;

   localparam logic [7:0]  RST_MAX_ITER = 8'd30;
   localparam logic [30:0] RST_TOL      = 31'd105;
   localparam logic [63:0] RST_RELAX    = 64'h0010_0000_0000_0000;
   localparam logic [63:0] RST_C3       = 64'h0010_0000_0000_0000;
   localparam logic [63:0] RST_C2       = 64'h0000_0000_0000_0000;
   localparam logic [63:0] RST_C1       = 64'hFFE0_0000_0000_0000;
   localparam logic [63:0] RST_C0       = 64'h0020_0000_0000_0000;

   typedef enum logic [2:0] {
      CSR_MAX_ITER = 3'd0,
      CSR_TOL      = 3'd1,
      CSR_RELAX    = 3'd2,
      CSR_C3       = 3'd3,
      CSR_C2       = 3'd4,
      CSR_C1       = 3'd5,
      CSR_C0       = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CONVERGED  = 2'd0,
      ST_LIMIT      = 2'd1,
      ST_ZERO_DERIV = 2'd2
   } status_code_type;

   typedef enum logic [3:0] {
      SRC_ZERO,
      SRC_D_RE, SRC_D_IM, SRC_ND_IM,
      SRC_F_RE, SRC_F_IM,
      SRC_Z_RE, SRC_Z_IM,
      SRC_A_RE, SRC_A_IM,
      SRC_NUM_RE, SRC_NUM_IM,
      SRC_DL_RE, SRC_DL_IM,
      SRC_TOL
   } src_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_FL_LOAD,
      ACC_FL_SUB,
      ACC_FL_ADD,
      ACC_W_LOAD,
      ACC_W_ADD
   } acc_op_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_TMP,
      WB_D,
      WB_F,
      WB_NUM,
      WB_TOL2,
      WB_DEN,
      WB_DIV_RE,
      WB_DIV_IM,
      WB_Z
   } wb_type;

   typedef enum logic [1:0] {
      ADD_ZERO,
      ADD_F,
      ADD_COEF
   } add_sel_type;

   typedef struct packed {
      logic                  load;
      logic                  init;
      src_type               mul_a;
      src_type               mul_b;
      acc_op_type            acc;
      wb_type                wb;
      add_sel_type           add_sel;
      logic [COEF_SEL_W-1:0] coef_sel;
      logic                  finish;
      status_code_type       status;
      logic [7:0]            iter;
   } cmd_type;

   typedef struct packed {
      logic d_zero;
      logic mag_lt_tol;
      logic div_done;
      logic out_full;
   } dp_status_type;

   typedef struct packed {
      logic [7:0]  max_iter;
      logic [30:0] tol;
      logic [63:0] relax;
      logic [63:0] c3;
      logic [63:0] c2;
      logic [63:0] c1;
      logic [63:0] c0;
   } cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sh0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -48'sh0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/nfpi_divider.sv */
// Computes floor(|n| * 2^20 / den) with sign and saturation, one quotient bit per cycle.
`include "newton_fractal_pixel_iterator_unit_assert.svh"

module nfpi_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [64:0] dividend,
   input  logic [63:0]        divisor,
   output logic               done,
   output logic signed [31:0] quotient
);

   localparam int QBITS = 31;
   localparam logic [4:0] LAST = 5'(QBITS - 1);

   logic        busy_ff, busy_in;
   logic        sat_ff, sat_in;
   logic        neg_ff, neg_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] rem_ff, rem_in;
   logic [QBITS-1:0] bits_ff, bits_in;
   logic [QBITS-1:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic        neg;
   logic [64:0] neg_val;
   logic [63:0] mag;
   logic        sat;
   logic [64:0] trial;
   logic        ge;
   logic [QBITS-1:0] q_next;

   always_comb begin
      neg     = dividend[64];
      neg_val = 65'(-dividend);
      mag     = neg ? neg_val[63:0] : dividend[63:0];
      // Quotient cannot fit in 31 bits when |n| >= den * 2^11.
      sat     = (divisor[63:53] == '0) && (mag >= {divisor[52:0], 11'b0});
      trial   = {rem_ff, bits_ff[QBITS-1]};
      ge      = trial >= {1'b0, den_ff};
      q_next  = {q_ff[QBITS-2:0], ge};
      done    = busy_ff && (sat_ff || cnt_ff == LAST);
      if (sat_ff) begin
         quotient = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (neg_ff) begin
         quotient = -$signed({1'b0, q_next});
      end else begin
         quotient = $signed({1'b0, q_next});
      end
   end

   always_comb begin
      busy_in = busy_ff;
      sat_in  = sat_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         sat_in  = sat;
         neg_in  = neg;
         den_in  = divisor;
         rem_in  = {11'b0, mag[63:11]};
         bits_in = {mag[10:0], 20'b0};
         q_in    = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (!sat_ff) begin
            rem_in  = ge ? 64'(trial - {1'b0, den_ff}) : trial[63:0];
            q_in    = q_next;
            bits_in = {bits_ff[QBITS-2:0], 1'b0};
            cnt_in  = cnt_ff + 5'd1;
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      sat_ff  <= sat_in;
      neg_ff  <= neg_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      q_ff    <= q_in;
   end

   `NFPI_ASSERT_SAME(a_start_idle, clock, reset, start, !busy_ff, "divider started while busy")
   `NFPI_ASSERT_NEXT(a_done_frees, clock, reset, done, !busy_ff, "divider still busy after done")
   `NFPI_ASSERT_SAME(a_cnt_range, clock, reset, busy_ff && !sat_ff, cnt_ff <= LAST,
                     "divider step count overran")

endmodule

/* hw/rtl/nfpi_datapath.sv */
module nfpi_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  nfpi_pkg::cfg_type      cfg,
   input  nfpi_pkg::cmd_type      cmd,
   output nfpi_pkg::dp_status_type status,
   input  logic signed [31:0]     req_start_re,
   input  logic signed [31:0]     req_start_im,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_iteration_index,
   output logic signed [31:0]     rsp_final_re,
   output logic signed [31:0]     rsp_final_im,
   output logic signed [31:0]     rsp_step_re,
   output logic signed [31:0]     rsp_step_im
);

   logic signed [31:0] z_re_ff, z_re_in, z_im_ff, z_im_in;
   logic signed [31:0] f_re_ff, f_re_in, f_im_ff, f_im_in;
   logic signed [31:0] d_re_ff, d_re_in, d_im_ff, d_im_in;
   logic signed [31:0] n_re_ff, n_re_in, n_im_ff, n_im_in;
   logic signed [31:0] dl_re_ff, dl_re_in, dl_im_ff, dl_im_in;
   logic signed [31:0] tmp_ff, tmp_in;
   logic signed [63:0] p_ff, p_in;
   logic signed [45:0] acc_ff, acc_in;
   logic signed [64:0] wide_ff, wide_in;
   logic [63:0]        den_ff, den_in;
   logic [63:0]        tol2_ff, tol2_in;
   logic               div_im_ff, div_im_in;

   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_status_ff, out_status_in;
   logic [7:0]         out_iter_ff, out_iter_in;
   logic signed [31:0] out_fre_ff, out_fre_in, out_fim_ff, out_fim_in;
   logic signed [31:0] out_sre_ff, out_sre_in, out_sim_ff, out_sim_in;

   logic signed [32:0] op_a, op_b;
   logic signed [65:0] product;
   logic signed [43:0] fl;
   logic signed [31:0] acc_sat;
   logic signed [31:0] add_re, add_im;
   logic signed [31:0] coef_re, coef_im;
   logic [63:0]        coef;
   logic               div_start, div_done;
   logic signed [31:0] div_q;

   function automatic logic signed [32:0] pick(
      input nfpi_pkg::src_type sel,
      input logic signed [31:0] d_re, d_im, f_re, f_im, z_re, z_im,
      input logic signed [31:0] a_re, a_im, n_re, n_im, dl_re, dl_im,
      input logic [30:0] tol);
      logic signed [32:0] v;
      case (sel)
         nfpi_pkg::SRC_D_RE:   v = 33'(d_re);
         nfpi_pkg::SRC_D_IM:   v = 33'(d_im);
         nfpi_pkg::SRC_ND_IM:  v = -33'(d_im);
         nfpi_pkg::SRC_F_RE:   v = 33'(f_re);
         nfpi_pkg::SRC_F_IM:   v = 33'(f_im);
         nfpi_pkg::SRC_Z_RE:   v = 33'(z_re);
         nfpi_pkg::SRC_Z_IM:   v = 33'(z_im);
         nfpi_pkg::SRC_A_RE:   v = 33'(a_re);
         nfpi_pkg::SRC_A_IM:   v = 33'(a_im);
         nfpi_pkg::SRC_NUM_RE: v = 33'(n_re);
         nfpi_pkg::SRC_NUM_IM: v = 33'(n_im);
         nfpi_pkg::SRC_DL_RE:  v = 33'(dl_re);
         nfpi_pkg::SRC_DL_IM:  v = 33'(dl_im);
         nfpi_pkg::SRC_TOL:    v = $signed({2'b00, tol});
         default:              v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      op_a = pick(cmd.mul_a, d_re_ff, d_im_ff, f_re_ff, f_im_ff, z_re_ff, z_im_ff,
                  $signed(cfg.relax[63:32]), $signed(cfg.relax[31:0]), n_re_ff, n_im_ff,
                  dl_re_ff, dl_im_ff, cfg.tol);
      op_b = pick(cmd.mul_b, d_re_ff, d_im_ff, f_re_ff, f_im_ff, z_re_ff, z_im_ff,
                  $signed(cfg.relax[63:32]), $signed(cfg.relax[31:0]), n_re_ff, n_im_ff,
                  dl_re_ff, dl_im_ff, cfg.tol);
      product = op_a * op_b;
      // Dropping the low fraction bits of a two's complement value floors it.
      fl      = p_ff[63:nfpi_pkg::FRAC];
      acc_sat = nfpi_pkg::sat32(48'(acc_ff));

      case (cmd.coef_sel)
         3'd0:    coef = cfg.c0;
         3'd1:    coef = cfg.c1;
         3'd2:    coef = cfg.c2;
         3'd3:    coef = cfg.c3;
         default: coef = '0;
      endcase
      coef_re = $signed(coef[63:32]);
      coef_im = $signed(coef[31:0]);

      case (cmd.add_sel)
         nfpi_pkg::ADD_F: begin
            add_re = f_re_ff;
            add_im = f_im_ff;
         end
         nfpi_pkg::ADD_COEF: begin
            add_re = coef_re;
            add_im = coef_im;
         end
         default: begin
            add_re = '0;
            add_im = '0;
         end
      endcase
   end

   assign div_start = (cmd.wb == nfpi_pkg::WB_DIV_RE) || (cmd.wb == nfpi_pkg::WB_DIV_IM);

   nfpi_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wide_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      z_re_in   = z_re_ff;
      z_im_in   = z_im_ff;
      f_re_in   = f_re_ff;
      f_im_in   = f_im_ff;
      d_re_in   = d_re_ff;
      d_im_in   = d_im_ff;
      n_re_in   = n_re_ff;
      n_im_in   = n_im_ff;
      dl_re_in  = dl_re_ff;
      dl_im_in  = dl_im_ff;
      tmp_in    = tmp_ff;
      p_in      = product[63:0];
      acc_in    = acc_ff;
      wide_in   = wide_ff;
      den_in    = den_ff;
      tol2_in   = tol2_ff;
      div_im_in = div_im_ff;

      if (cmd.load) begin
         z_re_in  = req_start_re;
         z_im_in  = req_start_im;
         dl_re_in = '0;
         dl_im_in = '0;
      end
      if (cmd.init) begin
         f_re_in = coef_re;
         f_im_in = coef_im;
         d_re_in = '0;
         d_im_in = '0;
      end

      case (cmd.acc)
         nfpi_pkg::ACC_FL_LOAD: acc_in = 46'(fl);
         nfpi_pkg::ACC_FL_SUB:  acc_in = acc_ff - 46'(fl);
         nfpi_pkg::ACC_FL_ADD:  acc_in = acc_ff + 46'(fl);
         nfpi_pkg::ACC_W_LOAD:  wide_in = 65'(p_ff);
         nfpi_pkg::ACC_W_ADD:   wide_in = wide_ff + 65'(p_ff);
         default: ;
      endcase

      case (cmd.wb)
         nfpi_pkg::WB_TMP: tmp_in = nfpi_pkg::sat32(48'(acc_sat) + 48'(add_re));
         nfpi_pkg::WB_D: begin
            d_re_in = tmp_ff;
            d_im_in = nfpi_pkg::sat32(48'(acc_sat) + 48'(add_im));
         end
         nfpi_pkg::WB_F: begin
            f_re_in = tmp_ff;
            f_im_in = nfpi_pkg::sat32(48'(acc_sat) + 48'(add_im));
         end
         nfpi_pkg::WB_NUM: begin
            n_re_in = tmp_ff;
            n_im_in = nfpi_pkg::sat32(48'(acc_sat) + 48'(add_im));
         end
         nfpi_pkg::WB_TOL2:   tol2_in = wide_ff[63:0];
         nfpi_pkg::WB_DEN:    den_in = wide_ff[63:0];
         nfpi_pkg::WB_DIV_RE: div_im_in = 1'b0;
         nfpi_pkg::WB_DIV_IM: div_im_in = 1'b1;
         nfpi_pkg::WB_Z: begin
            z_re_in = nfpi_pkg::sat32(48'(z_re_ff) - 48'(dl_re_ff));
            z_im_in = nfpi_pkg::sat32(48'(z_im_ff) - 48'(dl_im_ff));
         end
         default: ;
      endcase

      if (div_done) begin
         if (div_im_ff) begin
            dl_im_in = div_q;
         end else begin
            dl_re_in = div_q;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_iter_in   = out_iter_ff;
      out_fre_in    = out_fre_ff;
      out_fim_in    = out_fim_ff;
      out_sre_in    = out_sre_ff;
      out_sim_in    = out_sim_ff;
      if (cmd.finish) begin
         out_valid_in  = 1'b1;
         out_status_in = cmd.status;
         out_iter_in   = cmd.iter;
         out_fre_in    = z_re_ff;
         out_fim_in    = z_im_ff;
         out_sre_in    = dl_re_ff;
         out_sim_in    = dl_im_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      z_re_ff       <= z_re_in;
      z_im_ff       <= z_im_in;
      f_re_ff       <= f_re_in;
      f_im_ff       <= f_im_in;
      d_re_ff       <= d_re_in;
      d_im_ff       <= d_im_in;
      n_re_ff       <= n_re_in;
      n_im_ff       <= n_im_in;
      dl_re_ff      <= dl_re_in;
      dl_im_ff      <= dl_im_in;
      tmp_ff        <= tmp_in;
      p_ff          <= p_in;
      acc_ff        <= acc_in;
      wide_ff       <= wide_in;
      den_ff        <= den_in;
      tol2_ff       <= tol2_in;
      div_im_ff     <= div_im_in;
      out_status_ff <= out_status_in;
      out_iter_ff   <= out_iter_in;
      out_fre_ff    <= out_fre_in;
      out_fim_ff    <= out_fim_in;
      out_sre_ff    <= out_sre_in;
      out_sim_ff    <= out_sim_in;
   end

   always_comb begin
      status.d_zero     = (d_re_ff == '0) && (d_im_ff == '0);
      status.mag_lt_tol = wide_ff[63:0] < tol2_ff;
      status.div_done   = div_done;
      status.out_full   = out_valid_ff;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_iteration_index = out_iter_ff;
   assign rsp_final_re        = out_fre_ff;
   assign rsp_final_im        = out_fim_ff;
   assign rsp_step_re         = out_sre_ff;
   assign rsp_step_im         = out_sim_ff;

endmodule

/* hw/rtl/nfpi_ctrl.sv */
`include "newton_fractal_pixel_iterator_unit_assert.svh"

module nfpi_ctrl #(
   parameter int DEGREE = nfpi_pkg::DEGREE_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              max_iter,
   input  nfpi_pkg::dp_status_type status,
   output nfpi_pkg::cmd_type       cmd
);

   localparam int KW  = (DEGREE > 1) ? $clog2(DEGREE) : 1;
   localparam int CSW = nfpi_pkg::COEF_SEL_W;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK,
      S_CM0, S_CM1, S_CM2, S_CM3, S_CM4, S_CM5,
      S_ZCHK,
      S_PAIR0, S_PAIR1, S_PAIR2, S_PAIR3,
      S_DIVW, S_FIN
   } state_type;

   // Which complex product the multiply sequence is working on.
   typedef enum logic [1:0] { CV_D, CV_F, CV_NUM } cmul_type;

   // Which sum of two real products the pair sequence is working on.
   typedef enum logic [2:0] { PV_TOL, PV_DEN, PV_DRE, PV_DIM, PV_MAG } pair_type;

   state_type                 state_ff, state_in;
   logic [7:0]                it_ff, it_in;
   logic [KW-1:0]             k_ff, k_in;
   cmul_type                  cv_ff, cv_in;
   pair_type                  pv_ff, pv_in;
   nfpi_pkg::status_code_type code_ff, code_in;

   nfpi_pkg::src_type     x_re, x_im, y_re, y_im;
   nfpi_pkg::src_type     pa0, pb0, pa1, pb1;
   nfpi_pkg::add_sel_type add_sel;
   nfpi_pkg::wb_type      cm_dst;

   always_comb begin
      unique case (cv_ff)
         CV_D: begin
            x_re = nfpi_pkg::SRC_D_RE; x_im = nfpi_pkg::SRC_D_IM;
            y_re = nfpi_pkg::SRC_Z_RE; y_im = nfpi_pkg::SRC_Z_IM;
            add_sel = nfpi_pkg::ADD_F; cm_dst = nfpi_pkg::WB_D;
         end
         CV_F: begin
            x_re = nfpi_pkg::SRC_F_RE; x_im = nfpi_pkg::SRC_F_IM;
            y_re = nfpi_pkg::SRC_Z_RE; y_im = nfpi_pkg::SRC_Z_IM;
            add_sel = nfpi_pkg::ADD_COEF; cm_dst = nfpi_pkg::WB_F;
         end
         default: begin
            x_re = nfpi_pkg::SRC_A_RE; x_im = nfpi_pkg::SRC_A_IM;
            y_re = nfpi_pkg::SRC_F_RE; y_im = nfpi_pkg::SRC_F_IM;
            add_sel = nfpi_pkg::ADD_ZERO; cm_dst = nfpi_pkg::WB_NUM;
         end
      endcase

      unique case (pv_ff)
         PV_TOL: begin
            pa0 = nfpi_pkg::SRC_TOL; pb0 = nfpi_pkg::SRC_TOL;
            pa1 = nfpi_pkg::SRC_TOL; pb1 = nfpi_pkg::SRC_ZERO;
         end
         PV_DEN: begin
            pa0 = nfpi_pkg::SRC_D_RE; pb0 = nfpi_pkg::SRC_D_RE;
            pa1 = nfpi_pkg::SRC_D_IM; pb1 = nfpi_pkg::SRC_D_IM;
         end
         PV_DRE: begin
            pa0 = nfpi_pkg::SRC_NUM_RE; pb0 = nfpi_pkg::SRC_D_RE;
            pa1 = nfpi_pkg::SRC_NUM_IM; pb1 = nfpi_pkg::SRC_D_IM;
         end
         PV_DIM: begin
            pa0 = nfpi_pkg::SRC_NUM_IM; pb0 = nfpi_pkg::SRC_D_RE;
            pa1 = nfpi_pkg::SRC_NUM_RE; pb1 = nfpi_pkg::SRC_ND_IM;
         end
         default: begin
            pa0 = nfpi_pkg::SRC_DL_RE; pb0 = nfpi_pkg::SRC_DL_RE;
            pa1 = nfpi_pkg::SRC_DL_IM; pb1 = nfpi_pkg::SRC_DL_IM;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      it_in    = it_ff;
      k_in     = k_ff;
      cv_in    = cv_ff;
      pv_in    = pv_ff;
      code_in  = code_ff;

      cmd          = '0;
      cmd.iter     = it_ff;
      cmd.status   = code_ff;
      cmd.coef_sel = CSW'(k_ff);
      cmd.add_sel  = add_sel;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               it_in    = '0;
               pv_in    = PV_TOL;
               state_in = S_PAIR0;
            end
         end
         S_CHECK: begin
            if (it_ff == max_iter) begin
               code_in  = nfpi_pkg::ST_LIMIT;
               state_in = S_FIN;
            end else begin
               cmd.init     = 1'b1;
               cmd.coef_sel = CSW'(DEGREE);
               k_in         = KW'(DEGREE - 1);
               cv_in        = CV_D;
               state_in     = S_CM0;
            end
         end
         S_CM0: begin
            cmd.mul_a = x_re;
            cmd.mul_b = y_re;
            state_in  = S_CM1;
         end
         S_CM1: begin
            cmd.mul_a = x_im;
            cmd.mul_b = y_im;
            cmd.acc   = nfpi_pkg::ACC_FL_LOAD;
            state_in  = S_CM2;
         end
         S_CM2: begin
            cmd.mul_a = x_re;
            cmd.mul_b = y_im;
            cmd.acc   = nfpi_pkg::ACC_FL_SUB;
            state_in  = S_CM3;
         end
         S_CM3: begin
            // Real part is finished here while the imaginary sum restarts.
            cmd.mul_a = x_im;
            cmd.mul_b = y_re;
            cmd.acc   = nfpi_pkg::ACC_FL_LOAD;
            cmd.wb    = nfpi_pkg::WB_TMP;
            state_in  = S_CM4;
         end
         S_CM4: begin
            cmd.acc  = nfpi_pkg::ACC_FL_ADD;
            state_in = S_CM5;
         end
         S_CM5: begin
            cmd.wb = cm_dst;
            unique case (cv_ff)
               CV_D: begin
                  cv_in    = CV_F;
                  state_in = S_CM0;
               end
               CV_F: begin
                  if (k_ff == '0) begin
                     state_in = S_ZCHK;
                  end else begin
                     k_in     = k_ff - 1'b1;
                     cv_in    = CV_D;
                     state_in = S_CM0;
                  end
               end
               default: begin
                  pv_in    = PV_DEN;
                  state_in = S_PAIR0;
               end
            endcase
         end
         S_ZCHK: begin
            if (status.d_zero) begin
               code_in  = nfpi_pkg::ST_ZERO_DERIV;
               state_in = S_FIN;
            end else begin
               cv_in    = CV_NUM;
               state_in = S_CM0;
            end
         end
         S_PAIR0: begin
            cmd.mul_a = pa0;
            cmd.mul_b = pb0;
            state_in  = S_PAIR1;
         end
         S_PAIR1: begin
            cmd.mul_a = pa1;
            cmd.mul_b = pb1;
            cmd.acc   = nfpi_pkg::ACC_W_LOAD;
            state_in  = S_PAIR2;
         end
         S_PAIR2: begin
            cmd.acc  = nfpi_pkg::ACC_W_ADD;
            state_in = S_PAIR3;
         end
         S_PAIR3: begin
            unique case (pv_ff)
               PV_TOL: begin
                  cmd.wb   = nfpi_pkg::WB_TOL2;
                  state_in = S_CHECK;
               end
               PV_DEN: begin
                  cmd.wb   = nfpi_pkg::WB_DEN;
                  pv_in    = PV_DRE;
                  state_in = S_PAIR0;
               end
               PV_DRE: begin
                  cmd.wb   = nfpi_pkg::WB_DIV_RE;
                  state_in = S_DIVW;
               end
               PV_DIM: begin
                  cmd.wb   = nfpi_pkg::WB_DIV_IM;
                  state_in = S_DIVW;
               end
               default: begin
                  if (status.mag_lt_tol) begin
                     code_in  = nfpi_pkg::ST_CONVERGED;
                     state_in = S_FIN;
                  end else begin
                     cmd.wb   = nfpi_pkg::WB_Z;
                     it_in    = it_ff + 8'd1;
                     state_in = S_CHECK;
                  end
               end
            endcase
         end
         S_DIVW: begin
            if (status.div_done) begin
               pv_in    = (pv_ff == PV_DRE) ? PV_DIM : PV_MAG;
               state_in = S_PAIR0;
            end
         end
         S_FIN: begin
            if (!status.out_full) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         it_ff    <= '0;
         k_ff     <= '0;
         cv_ff    <= CV_D;
         pv_ff    <= PV_TOL;
         code_ff  <= nfpi_pkg::ST_LIMIT;
      end else begin
         state_ff <= state_in;
         it_ff    <= it_in;
         k_ff     <= k_in;
         cv_ff    <= cv_in;
         pv_ff    <= pv_in;
         code_ff  <= code_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `NFPI_ASSERT_SAME(a_iter_bound, clock, reset, state_ff != S_IDLE, it_ff <= max_iter,
                     "iteration count passed the limit")
   `NFPI_ASSERT_SAME(a_finish_room, clock, reset, cmd.finish, !status.out_full,
                     "result written over an undelivered one")
   `NFPI_ASSERT_SAME(a_divw_kind, clock, reset, state_ff == S_DIVW,
                     pv_ff == PV_DRE || pv_ff == PV_DIM, "divide wait outside a quotient step")

endmodule

/* hw/rtl/newton_fractal_pixel_iterator_unit.sv */
// Channel  Direction  Handshake          Transaction
// req      in         req_valid/stall    one starting point (start_re, start_im)
// rsp      out        rsp_valid/stall    status, iteration index, final z, last step
// csr      in         csr_valid/ready    register index and write data
//
// One shared 33x33 multiplier and a one-bit-per-cycle divider do all the work.
// Each iteration runs two complex Horner products per degree, the limit and derivative
// checks, the product a*f, four sums of two real products and two divides, each of
// which ends early when its quotient saturates.
// Reset is synchronous; it clears control state and restores register defaults.
// A new point is taken once the previous one has reached the output register,
// so a stalled result does not hold up taking the next point, only its delivery.
module newton_fractal_pixel_iterator_unit #(
   parameter int DEGREE = nfpi_pkg::DEGREE_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_start_re,
   input  logic signed [31:0] req_start_im,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_iteration_index,
   output logic signed [31:0] rsp_final_re,
   output logic signed [31:0] rsp_final_im,
   output logic signed [31:0] rsp_step_re,
   output logic signed [31:0] rsp_step_im,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   nfpi_pkg::cfg_type       cfg_ff, cfg_in;
   nfpi_pkg::cmd_type       cmd;
   nfpi_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (nfpi_pkg::csr_index_type'(csr_index))
            nfpi_pkg::CSR_MAX_ITER: cfg_in.max_iter = csr_data[7:0];
            nfpi_pkg::CSR_TOL:      cfg_in.tol      = csr_data[30:0];
            nfpi_pkg::CSR_RELAX:    cfg_in.relax    = csr_data;
            nfpi_pkg::CSR_C3:       cfg_in.c3       = csr_data;
            nfpi_pkg::CSR_C2:       cfg_in.c2       = csr_data;
            nfpi_pkg::CSR_C1:       cfg_in.c1       = csr_data;
            nfpi_pkg::CSR_C0:       cfg_in.c0       = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iter <= nfpi_pkg::RST_MAX_ITER;
         cfg_ff.tol      <= nfpi_pkg::RST_TOL;
         cfg_ff.relax    <= nfpi_pkg::RST_RELAX;
         cfg_ff.c3       <= nfpi_pkg::RST_C3;
         cfg_ff.c2       <= nfpi_pkg::RST_C2;
         cfg_ff.c1       <= nfpi_pkg::RST_C1;
         cfg_ff.c0       <= nfpi_pkg::RST_C0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nfpi_ctrl #(
      .DEGREE (DEGREE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .max_iter  (cfg_ff.max_iter),
      .status    (status),
      .cmd       (cmd)
   );

   nfpi_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .cmd                 (cmd),
      .status              (status),
      .req_start_re        (req_start_re),
      .req_start_im        (req_start_im),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_iteration_index (rsp_iteration_index),
      .rsp_final_re        (rsp_final_re),
      .rsp_final_im        (rsp_final_im),
      .rsp_step_re         (rsp_step_re),
      .rsp_step_im         (rsp_step_im)
   );

endmodule

/* tb/sv/testbench.sv */
module testbench;

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
   } cplx_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         iter;
      logic signed [31:0] final_re;
      logic signed [31:0] final_im;
      logic signed [31:0] step_re;
      logic signed [31:0] step_im;
   } point_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_start_re = '0;
   logic signed [31:0] req_start_im = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_iteration_index;
   logic signed [31:0] rsp_final_re;
   logic signed [31:0] rsp_final_im;
   logic signed [31:0] rsp_step_re;
   logic signed [31:0] rsp_step_im;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_data = '0;

   newton_fractal_pixel_iterator_unit dut (.*);

   always #6 clock = ~clock;

   // Shadow copy of the register file.
   logic [7:0]  iter_limit;
   logic [30:0] tol_reg;
   logic [63:0] relax_reg;
   logic [63:0] coef_reg [0:3];

   point_result_type pending_results [$];
   int error_count = 0;
   int points_sent = 0;
   int results_seen = 0;
   int csr_writes = 0;
   int hold_cycles = 0;
   int stall_mode = 0;
   bit gaps_on = 1'b0;

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic cplx_type cmul(cplx_type a, cplx_type b);
      longint ac, bd, ad, bc;
      cplx_type r;
      ac = (longint'(a.re) * longint'(b.re)) >>> nfpi_pkg::FRAC;
      bd = (longint'(a.im) * longint'(b.im)) >>> nfpi_pkg::FRAC;
      ad = (longint'(a.re) * longint'(b.im)) >>> nfpi_pkg::FRAC;
      bc = (longint'(a.im) * longint'(b.re)) >>> nfpi_pkg::FRAC;
      r.re = clamp32(ac - bd);
      r.im = clamp32(ad + bc);
      return r;
   endfunction

   function automatic cplx_type cadd(cplx_type a, cplx_type b);
      cplx_type r;
      r.re = clamp32(longint'(a.re) + longint'(b.re));
      r.im = clamp32(longint'(a.im) + longint'(b.im));
      return r;
   endfunction

   // Quotient of (p1 + p2) * 2^20 / den, magnitude truncated and saturated.
   function automatic logic signed [31:0] quotient_part(longint p1, longint p2,
                                                       longint unsigned den);
      logic signed [127:0] s;
      logic [127:0]        mag, q;
      logic [127:0]        den_w;
      bit                  neg;
      s = p1;
      s = s + p2;
      neg = s < 0;
      mag = neg ? -s : s;
      den_w = den;
      if (den_w < (128'd1 << 53) && mag >= (den_w << 11))
         return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      q = (mag << nfpi_pkg::FRAC) / den_w;
      return neg ? -q[31:0] : q[31:0];
   endfunction

   function automatic point_result_type iterate_point(logic signed [31:0] sre,
                                                      logic signed [31:0] sim);
      cplx_type z, dl, a, f, d, num;
      longint unsigned den, mag2, tol2;
      int it, k;
      point_result_type r;
      z.re = sre;
      z.im = sim;
      dl = '0;
      a = relax_reg;
      tol2 = longint'(tol_reg) * longint'(tol_reg);
      r.status = nfpi_pkg::ST_LIMIT;
      for (it = 0; it < iter_limit; it++) begin
         f = coef_reg[3];
         d = '0;
         for (k = 2; k >= 0; k--) begin
            d = cadd(cmul(d, z), f);
            f = cadd(cmul(f, z), cplx_type'(coef_reg[k]));
         end
         if (d.re == 0 && d.im == 0) begin
            r.status = nfpi_pkg::ST_ZERO_DERIV;
            break;
         end
         num = cmul(a, f);
         den = longint'(d.re) * longint'(d.re) + longint'(d.im) * longint'(d.im);
         dl.re = quotient_part(longint'(num.re) * longint'(d.re),
                               longint'(num.im) * longint'(d.im), den);
         dl.im = quotient_part(longint'(num.im) * longint'(d.re),
                               longint'(num.re) * -longint'(d.im), den);
         mag2 = longint'(dl.re) * longint'(dl.re) + longint'(dl.im) * longint'(dl.im);
         if (mag2 < tol2) begin
            r.status = nfpi_pkg::ST_CONVERGED;
            break;
         end
         z.re = clamp32(longint'(z.re) - longint'(dl.re));
         z.im = clamp32(longint'(z.im) - longint'(dl.im));
      end
      r.iter = it[7:0];
      r.final_re = z.re;
      r.final_im = z.im;
      r.step_re = dl.re;
      r.step_im = dl.im;
      return r;
   endfunction

   task automatic send_point(logic signed [31:0] sre, logic signed [31:0] sim);
      @(negedge clock);
      req_valid = 1'b1;
      req_start_re = sre;
      req_start_im = sim;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(iterate_point(sre, sim));
      points_sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic csr_write(nfpi_pkg::csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_writes++;
      case (idx)
         nfpi_pkg::CSR_MAX_ITER: iter_limit = value[7:0];
         nfpi_pkg::CSR_TOL:      tol_reg = value[30:0];
         nfpi_pkg::CSR_RELAX:    relax_reg = value;
         nfpi_pkg::CSR_C3:       coef_reg[3] = value;
         nfpi_pkg::CSR_C2:       coef_reg[2] = value;
         nfpi_pkg::CSR_C1:       coef_reg[1] = value;
         nfpi_pkg::CSR_C0:       coef_reg[0] = value;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_part();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
   endfunction

   // The receiver stalls on its own pattern; a hold-off request overrides it.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         case (stall_mode)
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      point_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result transaction with nothing expected");
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_iteration_index !== e.iter) begin
               $error("iteration_index expected %0d actual %0d", e.iter,
                      rsp_iteration_index);
               error_count++;
            end
            if (rsp_final_re !== e.final_re) begin
               $error("final_re expected %0d actual %0d", e.final_re, rsp_final_re);
               error_count++;
            end
            if (rsp_final_im !== e.final_im) begin
               $error("final_im expected %0d actual %0d", e.final_im, rsp_final_im);
               error_count++;
            end
            if (rsp_step_re !== e.step_re) begin
               $error("step_re expected %0d actual %0d", e.step_re, rsp_step_re);
               error_count++;
            end
            if (rsp_step_im !== e.step_im) begin
               $error("step_im expected %0d actual %0d", e.step_im, rsp_step_im);
               error_count++;
            end
         end
      end
   end

   task automatic test_defaults();
      send_point(32'sd0, 32'sd0);
      send_point(-32'sd1855000, 32'sd0);
      send_point(32'sd1048576, 32'sd1048576);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_point(32'sh8000_0000, 32'sh8000_0000);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
      drain();
   endtask

   task automatic test_register_extremes();
      csr_write(nfpi_pkg::CSR_MAX_ITER, 64'd1);
      send_point(32'sd524288, -32'sd524288);
      drain();
      csr_write(nfpi_pkg::CSR_MAX_ITER, 64'd255);
      csr_write(nfpi_pkg::CSR_TOL, 64'd0);
      send_point(-32'sd1855000, 32'sd0);
      drain();
      csr_write(nfpi_pkg::CSR_TOL, 64'h7FFF_FFFF);
      send_point(32'sd3000000, 32'sd123);
      drain();
      // With no derivative at all the loop stops on its first pass.
      csr_write(nfpi_pkg::CSR_TOL, 64'd105);
      csr_write(nfpi_pkg::CSR_C3, 64'd0);
      csr_write(nfpi_pkg::CSR_C2, 64'd0);
      csr_write(nfpi_pkg::CSR_C1, 64'd0);
      send_point(32'sd777, -32'sd999);
      drain();
      csr_write(nfpi_pkg::CSR_C1, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(nfpi_pkg::CSR_C0, 64'h8000_0000_7FFF_FFFF);
      csr_write(nfpi_pkg::CSR_RELAX, 64'd0);
      send_point(32'sd100, 32'sd200);
      drain();
      csr_write(nfpi_pkg::CSR_TOL, 64'd0);
      csr_write(nfpi_pkg::CSR_MAX_ITER, 64'd4);
      send_point(32'sd100, 32'sd200);
      drain();
      csr_write(nfpi_pkg::CSR_RELAX, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(nfpi_pkg::CSR_C3, 64'h7FFF_FFFF_8000_0000);
      csr_write(nfpi_pkg::CSR_C2, 64'h8000_0000_8000_0000);
      send_point(32'sh7FFF_FFFF, 32'sd0);
      send_point(32'sd0, 32'sh8000_0000);
      drain();
   endtask

   task automatic test_back_pressure();
      int n;
      csr_write(nfpi_pkg::CSR_MAX_ITER, 64'd2);
      csr_write(nfpi_pkg::CSR_RELAX, 64'h0010_0000_0000_0000);
      @(posedge clock);
      hold_cycles = 3000;
      for (n = 0; n < 8; n++) send_point(rand_part(), rand_part());
      drain();
   endtask

   task automatic test_random_points();
      int phase, n;
      gaps_on = 1'b1;
      for (phase = 0; phase < 8; phase++) begin
         stall_mode = phase % 3;
         csr_write(nfpi_pkg::CSR_MAX_ITER,
                   (phase == 7) ? 64'd40 : 64'($urandom_range(1, 10)));
         case ($urandom_range(0, 3))
            0: csr_write(nfpi_pkg::CSR_TOL, 64'($urandom_range(0, 2000)));
            1: csr_write(nfpi_pkg::CSR_TOL, 64'($urandom));
            default: csr_write(nfpi_pkg::CSR_TOL, 64'd105);
         endcase
         csr_write(nfpi_pkg::CSR_RELAX,
                   ($urandom_range(0, 1) == 0) ? 64'h0010_0000_0000_0000 :
                                                 {rand_part(), rand_part()});
         if (phase == 0) begin
            csr_write(nfpi_pkg::CSR_C3, nfpi_pkg::RST_C3);
            csr_write(nfpi_pkg::CSR_C2, nfpi_pkg::RST_C2);
            csr_write(nfpi_pkg::CSR_C1, nfpi_pkg::RST_C1);
            csr_write(nfpi_pkg::CSR_C0, nfpi_pkg::RST_C0);
         end else begin
            csr_write(nfpi_pkg::CSR_C3, {rand_part(), rand_part()});
            csr_write(nfpi_pkg::CSR_C2, {rand_part(), rand_part()});
            csr_write(nfpi_pkg::CSR_C1, {rand_part(), rand_part()});
            csr_write(nfpi_pkg::CSR_C0, {rand_part(), rand_part()});
         end
         for (n = 0; n < ((phase == 7) ? 20 : 65); n++) send_point(rand_part(), rand_part());
         drain();
      end
      gaps_on = 1'b0;
      stall_mode = 0;
   endtask

   initial begin
      iter_limit = nfpi_pkg::RST_MAX_ITER;
      tol_reg = nfpi_pkg::RST_TOL;
      relax_reg = nfpi_pkg::RST_RELAX;
      coef_reg[3] = nfpi_pkg::RST_C3;
      coef_reg[2] = nfpi_pkg::RST_C2;
      coef_reg[1] = nfpi_pkg::RST_C1;
      coef_reg[0] = nfpi_pkg::RST_C0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_defaults();
      test_register_extremes();
      test_back_pressure();
      test_random_points();
      $display("Covered %0d starting points, %0d results, %0d register writes,",
               points_sent, results_seen, csr_writes);
      $display("with register extremes, output hold-off and random stalls and gaps.");
      if (error_count == 0) begin
         $display("newton_fractal_pixel_iterator_unit verification clean");
      end else begin
         $display("newton_fractal_pixel_iterator_unit verification failed");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("newton_fractal_pixel_iterator_unit verification failed");
      $finish;
   end

endmodule
